// ===== design/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder package
// Types and character constants shared by the front end, the back end and
// the top level of the chunked body decoder.
// ----------------------------------------------------------------------------
package chd_pkg;

   localparam logic [7:0] CH_CR  = 8'h0D;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_SP  = 8'h20;
   localparam logic [7:0] CH_TAB = 8'h09;

   // Bits per hex digit of the size line.
   localparam int HEX_DIGIT_BITS = 4;

   localparam int COUNT_BITS = 32;

   typedef enum logic [2:0] {
      PH_START    = 3'd0,
      PH_LEAD     = 3'd1,
      PH_DIGITS   = 3'd2,
      PH_REST     = 3'd3,
      PH_DATA     = 3'd4,
      PH_AFTER    = 3'd5,
      PH_AFTER_CR = 3'd6,
      PH_DONE     = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      END_NONE      = 2'd0,
      END_COMPLETE  = 2'd1,
      END_TRUNCATED = 2'd2
   } end_kind_type;

   // One raw byte after classification by the front end.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_hex;
      logic [3:0] hex_val;
      logic       is_blank;
      logic       is_cr;
      logic       is_lf;
   } class_type;

   // One result item as it waits in the result queue.
   typedef struct packed {
      logic [7:0]            byte_out;
      logic                  has_byte;
      end_kind_type          end_kind;
      logic [COUNT_BITS-1:0] body_length;
   } rsp_type;

endpackage

// ===== design/chd_fifo.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder queue
// Small first-in first-out queue of registers with push/full and pop/empty
// sides; a push and a pop may happen in the same cycle.
// ----------------------------------------------------------------------------
module chd_fifo #(
   parameter int WIDTH      = 8,
   parameter int DEPTH_LOG2 = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int DEPTH = 1 << DEPTH_LOG2;

   logic [WIDTH-1:0]      mem_ff [DEPTH];
   logic [DEPTH_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [DEPTH_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [DEPTH_LOG2:0]   count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign full    = (count_ff == (DEPTH_LOG2 + 1)'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ===== design/chd_front.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder front end
// Classifies each incoming byte (hex digit and its value, blank, CR, LF) so
// the back end only has to follow its state machine.
// ----------------------------------------------------------------------------
module chd_front
   import chd_pkg::*;
(
   input  logic [7:0] byte_in,
   input  logic       last_byte,
   output class_type  item
);

   always_comb begin
      item.data     = byte_in;
      item.last     = last_byte;
      item.is_hex   = 1'b0;
      item.hex_val  = 4'd0;
      item.is_blank = (byte_in == CH_SP) || (byte_in == CH_TAB);
      item.is_cr    = (byte_in == CH_CR);
      item.is_lf    = (byte_in == CH_LF);
      if (byte_in inside {[8'h30:8'h39]}) begin
         item.is_hex  = 1'b1;
         item.hex_val = byte_in[3:0];
      end else if (byte_in inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         // Upper and lower case letters share the low bits: A is 0x41, a is 0x61.
         item.is_hex  = 1'b1;
         item.hex_val = byte_in[3:0] + 4'd9;
      end
   end

endmodule

// ===== design/chd_back.sv =====
// ----------------------------------------------------------------------------
// Chunked body decoder back end
// Runs the size line and payload state machine on classified bytes and
// builds the result items.
// ----------------------------------------------------------------------------
module chd_back
   import chd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic      clock,
   input  logic      reset,
   input  class_type in_item,
   input  logic      in_valid,
   output logic      in_pop,
   output rsp_type   out_item,
   output logic      out_push,
   input  logic      out_full
);

   phase_type             phase_ff, phase_in;
   logic [SIZE_BITS-1:0]  acc_ff, acc_in;
   logic [SIZE_BITS-1:0]  rem_ff, rem_in;
   logic                  saw_cr_ff, saw_cr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   logic                  take;
   logic                  emit;
   logic                  lb_en;
   phase_type             lb_phase;
   logic                  lb_saw;
   logic [SIZE_BITS-1:0]  acc_add;
   logic [SIZE_BITS-1:0]  rem_dec;

   assign take   = in_valid && !out_full;
   assign in_pop = take;

   // Shift in one hex digit; saturate once the top digit is already in use.
   assign acc_add = (|acc_ff[SIZE_BITS-1 -: HEX_DIGIT_BITS]) ? '1 :
                    {acc_ff[SIZE_BITS-HEX_DIGIT_BITS-1:0], in_item.hex_val};
   assign rem_dec = (rem_ff != '0) ? rem_ff - 1'b1 : rem_ff;

   // Next state.
   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      rem_in    = rem_ff;
      saw_cr_in = saw_cr_ff;
      count_in  = count_ff;
      emit      = 1'b0;
      lb_en     = 1'b0;
      lb_phase  = phase_ff;
      lb_saw    = saw_cr_ff;
      case (phase_ff)
         PH_DATA: begin
            emit = 1'b1;
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            rem_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_AFTER;
            end
         end
         PH_AFTER: begin
            if (in_item.is_cr) begin
               phase_in = PH_AFTER_CR;
            end else begin
               lb_en    = 1'b1;
               lb_phase = PH_START;
            end
         end
         PH_AFTER_CR: begin
            if (in_item.is_lf) begin
               phase_in = PH_START;
            end else begin
               // A lone CR counts as a leading blank of the next size line.
               lb_en    = 1'b1;
               lb_phase = PH_LEAD;
               lb_saw   = 1'b0;
            end
         end
         PH_DONE: begin
         end
         default: begin
            lb_en = 1'b1;
         end
      endcase

      if (lb_en) begin
         phase_in = lb_phase;
         if (in_item.is_lf && lb_saw) begin
            saw_cr_in = 1'b0;
            if (acc_ff == '0) begin
               phase_in = PH_DONE;
            end else begin
               rem_in   = acc_ff;
               acc_in   = '0;
               phase_in = PH_DATA;
            end
         end else begin
            saw_cr_in = in_item.is_cr;
            if (lb_phase == PH_START || lb_phase == PH_LEAD) begin
               if (in_item.is_blank) begin
                  phase_in = PH_LEAD;
               end else if (in_item.is_hex) begin
                  acc_in   = acc_add;
                  phase_in = PH_DIGITS;
               end else begin
                  phase_in = PH_REST;
               end
            end else if (lb_phase == PH_DIGITS) begin
               if (in_item.is_hex) begin
                  acc_in = acc_add;
               end else begin
                  phase_in = PH_REST;
               end
            end
         end
      end
   end

   // Result item.
   always_comb begin
      out_push             = take && (emit || in_item.last);
      out_item.byte_out    = emit ? in_item.data : 8'd0;
      out_item.has_byte    = emit;
      out_item.body_length = count_in;
      out_item.end_kind    = END_NONE;
      if (in_item.last) begin
         if (phase_in == PH_START || phase_in == PH_AFTER ||
             phase_in == PH_AFTER_CR || phase_in == PH_DONE) begin
            out_item.end_kind = END_COMPLETE;
         end else begin
            out_item.end_kind = END_TRUNCATED;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         acc_ff    <= '0;
         rem_ff    <= '0;
         saw_cr_ff <= 1'b0;
         count_ff  <= '0;
      end else if (take) begin
         if (in_item.last) begin
            // The buffer ends here; the next byte starts a new body.
            phase_ff  <= PH_START;
            acc_ff    <= '0;
            rem_ff    <= '0;
            saw_cr_ff <= 1'b0;
            count_ff  <= '0;
         end else begin
            phase_ff  <= phase_in;
            acc_ff    <= acc_in;
            rem_ff    <= rem_in;
            saw_cr_ff <= saw_cr_in;
            count_ff  <= count_in;
         end
      end
   end

endmodule

// ===== design/http_chunked_body_decoder.sv =====
// ----------------------------------------------------------------------------
// HTTP chunked body decoder
// Strips the chunk framing of an HTTP/1.1 chunked body, byte by byte, and
// passes on the payload bytes with a running length and an end report.
// ----------------------------------------------------------------------------
// The decoder takes one raw body byte per item and sustains one item per
// clock cycle as long as results are popped as they arrive. An accepted
// byte waits in the input queue; the back end takes it out once the result
// queue has room and writes its result into the result queue, from which
// it can be popped. The rate is set by the back end's state machine, which
// looks at one byte per cycle when the result queue has room, and the
// two-entry queues on both sides let the input keep flowing while a
// result waits to be popped. Each chunk starts with a size line: spaces and
// tabs are skipped, hex digits are collected (a size too large for SIZE_BITS
// saturates to all ones), the rest of the line is ignored up to CR LF, and the
// payload bytes that follow are emitted one result item each. An optional
// CR LF after the payload is skipped. A size line without digits, or a size
// of zero, ends the body; later bytes are dropped until the byte flagged
// last_byte. That byte always yields a result whose end_kind tells whether the
// body ended cleanly (at a chunk boundary or after the zero chunk) or was
// cut mid-line or mid-chunk; bytes of a cut chunk have already been emitted.
// After it the decoder starts fresh on the next body. body_length is the
// count of payload bytes so far, saturating at all ones. Framing bytes that
// end nothing produce no result item.
module http_chunked_body_decoder
   import chd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_byte_in,
   input  logic                  req_last_byte,
   input  logic                  push,
   output logic                  full,
   output logic [7:0]            rsp_byte_out,
   output logic                  rsp_has_byte,
   output logic [1:0]            rsp_end_kind,
   output logic [COUNT_BITS-1:0] rsp_body_length,
   output logic                  empty,
   input  logic                  pop
);

   class_type front_item;
   class_type mid_item;
   logic      mid_empty;
   logic      mid_pop;
   rsp_type   back_item;
   logic      back_push;
   logic      out_full;
   rsp_type   out_item;

   // Front end: classify the raw byte on its way into the input queue.
   chd_front u_front (
      .byte_in   (req_byte_in),
      .last_byte (req_last_byte),
      .item      (front_item)
   );

   chd_fifo #(
      .WIDTH      ($bits(class_type)),
      .DEPTH_LOG2 (1)
   ) u_mid_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .wr_data (front_item),
      .full    (full),
      .pop     (mid_pop),
      .rd_data (mid_item),
      .empty   (mid_empty)
   );

   // Back end: framing state machine, one byte per cycle when it may proceed.
   chd_back #(
      .SIZE_BITS (SIZE_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .in_item  (mid_item),
      .in_valid (!mid_empty),
      .in_pop   (mid_pop),
      .out_item (back_item),
      .out_push (back_push),
      .out_full (out_full)
   );

   chd_fifo #(
      .WIDTH      ($bits(rsp_type)),
      .DEPTH_LOG2 (1)
   ) u_out_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (back_push),
      .wr_data (back_item),
      .full    (out_full),
      .pop     (pop),
      .rd_data (out_item),
      .empty   (empty)
   );

   assign rsp_byte_out    = out_item.byte_out;
   assign rsp_has_byte    = out_item.has_byte;
   assign rsp_end_kind    = out_item.end_kind;
   assign rsp_body_length = out_item.body_length;

   // The back end never hands a result to a full result queue.
   assert property (@(posedge clock) disable iff (reset) back_push |-> !out_full)
      else $error("result pushed into a full result queue");

   // Every result item carries either a payload byte or an end report.
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_has_byte || rsp_end_kind != END_NONE))
      else $error("result item with neither byte nor end report");

   // A result without a payload byte shows a zero byte.
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_has_byte) |-> (rsp_byte_out == 8'd0))
      else $error("framing result with a nonzero byte");

   // Right after reset nothing waits on the result side.
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> empty)
      else $error("result present right after reset");

endmodule
